FILE: hdl/mqttpf_pkg.sv
`default_nettype none

package mqttpf_pkg;

    // Default sizing
    localparam int BUF_BYTES_DEF         = 1024;
    localparam int ACK_TIMEOUT_TICKS_DEF = 50;

    // Position counters and packet length
    localparam int POS_W  = 11;
    localparam int PLEN_W = 12;
    localparam int QUEUE_DEPTH = 5;

    // Input operations
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_MSG   = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTOPIC = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Control packet types (high nibble)
    localparam logic [3:0] TYPE_PUBACK  = 4'd4;
    localparam logic [3:0] TYPE_PUBREC  = 4'd5;
    localparam logic [3:0] TYPE_PUBCOMP = 4'd7;

    // Header bytes and flags
    localparam logic [7:0] HDR_PUBLISH = 8'h30;
    localparam logic [7:0] FLAG_DUP    = 8'h08;
    localparam logic [7:0] FLAG_QOS1   = 8'h02;
    localparam logic [7:0] FLAG_QOS2   = 8'h04;
    localparam logic [7:0] HDR_PUBREL  = 8'h62;
    localparam logic [7:0] LEN_PUBREL  = 8'h02;
    localparam logic [15:0] ID_WRAP    = 16'd65000;

    // One queued result beat
    typedef struct packed {
        logic             kind;
        logic [7:0]       tx_byte;
        logic             last;
        logic [1:0]       status;
        logic             wr;
        logic [POS_W-1:0] addr;
    } beat_t;

endpackage

`default_nettype wire

FILE: hdl/mqtt_publish_framer_ack.sv
// An item's result beats pass through the result queue and then the output reg;
// a resend tick's beat is first read from the store into a read register.
// A new item is accepted only when the queue is empty and no store read is
// pending. Results drain one beat per cycle while out_ready is high,
// through a 5-entry queue and an output reg.
// Reset: control state cleared, packet id set to 1; packet store not cleared.
`default_nettype none

module mqtt_publish_framer_ack #(
    parameter int BUF_BYTES         = mqttpf_pkg::BUF_BYTES_DEF,
    parameter int ACK_TIMEOUT_TICKS = mqttpf_pkg::ACK_TIMEOUT_TICKS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [1:0] qos,
    input  wire logic       retain,
    input  wire logic [9:0] topic_len,
    input  wire logic [9:0] payload_len,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      tx_byte,
    output logic            last,
    output logic [1:0]      status
);

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int POS_W  = mqttpf_pkg::POS_W;
    localparam int PLEN_W = mqttpf_pkg::PLEN_W;
    localparam int QD     = mqttpf_pkg::QUEUE_DEPTH;

    typedef enum logic [1:0] {PH_IDLE, PH_COLLECT, PH_WAIT, PH_RESEND} phase_t;

    function automatic mqttpf_pkg::beat_t mk_beat(input logic k, input logic [7:0] d,
                                                   input logic l, input logic [1:0] s,
                                                   input logic w, input logic [POS_W-1:0] a);
        mqttpf_pkg::beat_t r;
        r.kind    = k;
        r.tx_byte = d;
        r.last    = l;
        r.status  = s;
        r.wr      = w;
        r.addr    = a;
        return r;
    endfunction

    // Control and held state
    phase_t              phase_reg, phase_next;
    logic [15:0]         id_reg, id_next;
    logic [1:0]          qos_reg, qos_next;
    logic [9:0]          topic_reg, topic_next;
    logic                two_reg, two_next;
    logic [PLEN_W-1:0]   plen_reg, plen_next;
    logic [POS_W-1:0]    wpos_reg, wpos_next;
    logic [POS_W-1:0]    rpos_reg, rpos_next;
    logic [3:0]          exp_reg, exp_next;
    logic [5:0]          wcnt_reg, wcnt_next;
    logic                retry_reg, retry_next;
    logic [1:0]          abc_reg, abc_next;
    logic [7:0]          ackhi_reg, ackhi_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                rd_last_reg, rd_last_next;
    logic                rd_dup_reg, rd_dup_next;

    // Result queue and output register
    mqttpf_pkg::beat_t   q_reg [QD];
    mqttpf_pkg::beat_t   nq [QD];
    logic [2:0]          q_cnt_reg;
    logic [2:0]          ncnt;
    logic                load;
    logic                q_move;
    logic                out_valid_reg;
    mqttpf_pkg::beat_t   out_reg;

    // Packet store
    logic [7:0]          mem [BUF_BYTES];
    logic [7:0]          rdata_reg;
    logic                rd_en;

    // Scratch for the combinational step
    logic                in_fire;
    logic [1:0]          qe;
    logic [PLEN_W-1:0]   rem;
    logic [15:0]         idinc, idn;
    logic                two;
    logic [PLEN_W-1:0]   plen_s;
    logic [7:0]          hdr;
    logic [POS_W-1:0]    wp1, wp2, wp3, wpf, rp1;
    logic                hit;
    logic [2:0]          n;
    logic [5:0]          wc1;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (q_cnt_reg == 3'd0) && !rd_pend_reg;
    assign q_move   = (q_cnt_reg != 3'd0) && (!out_valid_reg || out_ready);

    // Start-item header figures
    always_comb
    begin
        qe     = (qos == 2'd3) ? 2'd2 : qos;
        rem    = PLEN_W'(2) + PLEN_W'(topic_len) + PLEN_W'(payload_len)
                 + ((qe != 2'd0) ? PLEN_W'(2) : PLEN_W'(0));
        idinc  = id_reg + 16'd1;
        idn    = (idinc > mqttpf_pkg::ID_WRAP) ? 16'd1 : idinc;
        two    = rem >= PLEN_W'(128);
        plen_s = rem + (two ? PLEN_W'(3) : PLEN_W'(2));
        hdr    = mqttpf_pkg::HDR_PUBLISH | {7'b0, retain}
                 | ((qe == 2'd1) ? mqttpf_pkg::FLAG_QOS1 : 8'h00)
                 | ((qe == 2'd2) ? mqttpf_pkg::FLAG_QOS2 : 8'h00);
    end

    // Per-item step
    always_comb
    begin
        phase_next   = phase_reg;
        id_next      = id_reg;
        qos_next     = qos_reg;
        topic_next   = topic_reg;
        two_next     = two_reg;
        plen_next    = plen_reg;
        wpos_next    = wpos_reg;
        rpos_next    = rpos_reg;
        exp_next     = exp_reg;
        wcnt_next    = wcnt_reg;
        retry_next   = retry_reg;
        abc_next     = abc_reg;
        ackhi_next   = ackhi_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        rd_dup_next  = rd_dup_reg;
        rd_en        = 1'b0;
        load         = 1'b0;
        ncnt         = 3'd0;
        n            = 3'd0;
        hit          = 1'b0;
        wp1          = wpos_reg + POS_W'(1);
        wp2          = wpos_reg + POS_W'(2);
        wp3          = wpos_reg + POS_W'(3);
        wpf          = wp1;
        rp1          = rpos_reg + POS_W'(1);
        wc1          = wcnt_reg + 6'd1;
        for (int i = 0; i < QD; i++)
        begin
            nq[i] = '0;
        end

        if (rd_pend_reg)
        begin
            // Resend beat from the store
            load  = 1'b1;
            ncnt  = 3'd1;
            nq[0] = mk_beat(mqttpf_pkg::KIND_TX,
                            rdata_reg | (rd_dup_reg ? mqttpf_pkg::FLAG_DUP : 8'h00),
                            rd_last_reg, mqttpf_pkg::ST_OK, 1'b0, '0);
        end
        else if (in_fire)
        begin
            load = 1'b1;
            case (op)
                mqttpf_pkg::OP_START:
                begin
                    phase_next = PH_IDLE;
                    retry_next = 1'b0;
                    wcnt_next  = 6'd0;
                    abc_next   = 2'd0;
                    qos_next   = qe;
                    topic_next = topic_len;
                    if (topic_len == 10'd0)
                    begin
                        nq[0] = mk_beat(mqttpf_pkg::KIND_STATUS, 8'h00, 1'b0,
                                        mqttpf_pkg::ST_NOTOPIC, 1'b0, '0);
                        ncnt  = 3'd1;
                    end
                    else
                    begin
                        if (qe != 2'd0)
                        begin
                            id_next = idn;
                        end
                        if (({1'b0, rem} + 13'd5) > 13'(BUF_BYTES))
                        begin
                            nq[0] = mk_beat(mqttpf_pkg::KIND_STATUS, 8'h00, 1'b0,
                                            mqttpf_pkg::ST_TOOBIG, 1'b0, '0);
                            ncnt  = 3'd1;
                        end
                        else
                        begin
                            plen_next  = plen_s;
                            two_next   = two;
                            phase_next = PH_COLLECT;
                            nq[0] = mk_beat(mqttpf_pkg::KIND_TX, hdr,
                                            plen_s == PLEN_W'(1), mqttpf_pkg::ST_OK,
                                            1'b1, POS_W'(0));
                            if (two)
                            begin
                                nq[1] = mk_beat(mqttpf_pkg::KIND_TX, {1'b1, rem[6:0]},
                                                plen_s == PLEN_W'(2), mqttpf_pkg::ST_OK,
                                                1'b1, POS_W'(1));
                                nq[2] = mk_beat(mqttpf_pkg::KIND_TX, 8'(rem >> 7),
                                                plen_s == PLEN_W'(3), mqttpf_pkg::ST_OK,
                                                1'b1, POS_W'(2));
                                nq[3] = mk_beat(mqttpf_pkg::KIND_TX,
                                                {6'b0, topic_len[9:8]},
                                                plen_s == PLEN_W'(4), mqttpf_pkg::ST_OK,
                                                1'b1, POS_W'(3));
                                nq[4] = mk_beat(mqttpf_pkg::KIND_TX, topic_len[7:0],
                                                plen_s == PLEN_W'(5), mqttpf_pkg::ST_OK,
                                                1'b1, POS_W'(4));
                                ncnt      = 3'd5;
                                wpos_next = POS_W'(5);
                            end
                            else
                            begin
                                nq[1] = mk_beat(mqttpf_pkg::KIND_TX, rem[7:0],
                                                plen_s == PLEN_W'(2), mqttpf_pkg::ST_OK,
                                                1'b1, POS_W'(1));
                                nq[2] = mk_beat(mqttpf_pkg::KIND_TX,
                                                {6'b0, topic_len[9:8]},
                                                plen_s == PLEN_W'(3), mqttpf_pkg::ST_OK,
                                                1'b1, POS_W'(2));
                                nq[3] = mk_beat(mqttpf_pkg::KIND_TX, topic_len[7:0],
                                                plen_s == PLEN_W'(4), mqttpf_pkg::ST_OK,
                                                1'b1, POS_W'(3));
                                ncnt      = 3'd4;
                                wpos_next = POS_W'(4);
                            end
                        end
                    end
                end

                mqttpf_pkg::OP_MSG:
                begin
                    if (phase_reg == PH_COLLECT)
                    begin
                        nq[0] = mk_beat(mqttpf_pkg::KIND_TX, data_byte,
                                        {1'b0, wp1} == plen_reg, mqttpf_pkg::ST_OK,
                                        1'b1, wpos_reg);
                        hit = (qos_reg != 2'd0) && ({1'b0, wp1} ==
                              ((two_reg ? PLEN_W'(5) : PLEN_W'(4)) + PLEN_W'(topic_reg)));
                        if (hit)
                        begin
                            // Packet id goes right after the topic
                            nq[1] = mk_beat(mqttpf_pkg::KIND_TX, id_reg[15:8],
                                            {1'b0, wp2} == plen_reg, mqttpf_pkg::ST_OK,
                                            1'b1, wp1);
                            nq[2] = mk_beat(mqttpf_pkg::KIND_TX, id_reg[7:0],
                                            {1'b0, wp3} == plen_reg, mqttpf_pkg::ST_OK,
                                            1'b1, wp2);
                            wpf = wp3;
                            n   = 3'd3;
                        end
                        else
                        begin
                            wpf = wp1;
                            n   = 3'd1;
                        end
                        wpos_next = wpf;
                        if ({1'b0, wpf} >= plen_reg)
                        begin
                            if (qos_reg == 2'd0)
                            begin
                                phase_next = PH_IDLE;
                                nq[n] = mk_beat(mqttpf_pkg::KIND_STATUS, 8'h00, 1'b0,
                                                mqttpf_pkg::ST_OK, 1'b0, '0);
                                n = n + 3'd1;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                                exp_next   = (qos_reg == 2'd1) ? mqttpf_pkg::TYPE_PUBACK
                                                               : mqttpf_pkg::TYPE_PUBREC;
                                wcnt_next  = 6'd0;
                                abc_next   = 2'd0;
                            end
                        end
                        ncnt = n;
                    end
                end

                mqttpf_pkg::OP_RX:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        case (abc_reg)
                            2'd0:
                            begin
                                if (data_byte[7:4] == exp_reg)
                                begin
                                    abc_next = 2'd1;
                                end
                            end
                            2'd1:
                            begin
                                abc_next = 2'd2;
                            end
                            2'd2:
                            begin
                                ackhi_next = data_byte;
                                abc_next   = 2'd3;
                            end
                            default:
                            begin
                                abc_next = 2'd0;
                                if ({ackhi_reg, data_byte} == id_reg)
                                begin
                                    if (exp_reg == mqttpf_pkg::TYPE_PUBREC)
                                    begin
                                        // PUBREL answer
                                        nq[0] = mk_beat(mqttpf_pkg::KIND_TX,
                                                        mqttpf_pkg::HDR_PUBREL, 1'b0,
                                                        mqttpf_pkg::ST_OK, 1'b0, '0);
                                        nq[1] = mk_beat(mqttpf_pkg::KIND_TX,
                                                        mqttpf_pkg::LEN_PUBREL, 1'b0,
                                                        mqttpf_pkg::ST_OK, 1'b0, '0);
                                        nq[2] = mk_beat(mqttpf_pkg::KIND_TX, id_reg[15:8],
                                                        1'b0, mqttpf_pkg::ST_OK, 1'b0, '0);
                                        nq[3] = mk_beat(mqttpf_pkg::KIND_TX, id_reg[7:0],
                                                        1'b1, mqttpf_pkg::ST_OK, 1'b0, '0);
                                        ncnt      = 3'd4;
                                        exp_next  = mqttpf_pkg::TYPE_PUBCOMP;
                                        wcnt_next = 6'd0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_IDLE;
                                        nq[0] = mk_beat(mqttpf_pkg::KIND_STATUS, 8'h00,
                                                        1'b0, mqttpf_pkg::ST_OK, 1'b0, '0);
                                        ncnt  = 3'd1;
                                    end
                                end
                            end
                        endcase
                    end
                end

                default:
                begin
                    // Tick
                    if (phase_reg == PH_WAIT)
                    begin
                        wcnt_next = wc1;
                        if (wc1 >= 6'(ACK_TIMEOUT_TICKS))
                        begin
                            if (!retry_reg)
                            begin
                                retry_next = 1'b1;
                                rpos_next  = '0;
                                phase_next = PH_RESEND;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                nq[0] = mk_beat(mqttpf_pkg::KIND_STATUS, 8'h00, 1'b0,
                                                mqttpf_pkg::ST_TIMEOUT, 1'b0, '0);
                                ncnt  = 3'd1;
                            end
                        end
                    end
                    else if (phase_reg == PH_RESEND)
                    begin
                        // Store read; the beat follows next cycle
                        rd_en        = 1'b1;
                        rd_pend_next = 1'b1;
                        rd_dup_next  = (rpos_reg == '0);
                        rd_last_next = ({1'b0, rp1} >= plen_reg);
                        rpos_next    = rp1;
                        if ({1'b0, rp1} >= plen_reg)
                        begin
                            phase_next = PH_WAIT;
                            exp_next   = (qos_reg == 2'd1) ? mqttpf_pkg::TYPE_PUBACK
                                                           : mqttpf_pkg::TYPE_PUBREC;
                            wcnt_next  = 6'd0;
                            abc_next   = 2'd0;
                        end
                    end
                end
            endcase
        end
    end

    // Control registers, queue and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            id_reg        <= 16'd1;
            qos_reg       <= 2'd0;
            topic_reg     <= 10'd0;
            two_reg       <= 1'b0;
            plen_reg      <= '0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            exp_reg       <= 4'd0;
            wcnt_reg      <= 6'd0;
            retry_reg     <= 1'b0;
            abc_reg       <= 2'd0;
            ackhi_reg     <= 8'd0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            rd_dup_reg    <= 1'b0;
            q_cnt_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            id_reg      <= id_next;
            qos_reg     <= qos_next;
            topic_reg   <= topic_next;
            two_reg     <= two_next;
            plen_reg    <= plen_next;
            wpos_reg    <= wpos_next;
            rpos_reg    <= rpos_next;
            exp_reg     <= exp_next;
            wcnt_reg    <= wcnt_next;
            retry_reg   <= retry_next;
            abc_reg     <= abc_next;
            ackhi_reg   <= ackhi_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
            rd_dup_reg  <= rd_dup_next;
            if (load)
            begin
                q_cnt_reg <= ncnt;
            end
            else if (q_move)
            begin
                q_cnt_reg <= q_cnt_reg - 3'd1;
            end
            if (q_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Queue payload and output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < QD; i++)
            begin
                q_reg[i] <= nq[i];
            end
        end
        else if (q_move)
        begin
            for (int i = 0; i < QD - 1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
        if (q_move)
        begin
            out_reg <= q_reg[0];
        end
    end

    // Packet store: written as beats leave the queue, read for the resend
    always_ff @(posedge clk)
    begin
        if (q_move && q_reg[0].wr)
        begin
            mem[ADDR_W'(q_reg[0].addr)] <= q_reg[0].tx_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[ADDR_W'(rpos_reg)];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign tx_byte   = out_reg.tx_byte;
    assign last      = out_reg.last;
    assign status    = out_reg.status;

    // Checks
    a_qcnt: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 3'(QD))
        else $error("result queue overfilled");

    a_rd_one: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> !rd_pend_reg)
        else $error("store read pending twice");

    a_rd_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (q_cnt_reg == 3'd0))
        else $error("store data arrives over a busy queue");

    a_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (exp_reg == mqttpf_pkg::TYPE_PUBACK
            || exp_reg == mqttpf_pkg::TYPE_PUBREC || exp_reg == mqttpf_pkg::TYPE_PUBCOMP))
        else $error("bad expected ack type");

    a_resend: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == mqttpf_pkg::OP_TICK && phase_reg == PH_RESEND) |=> rd_pend_reg)
        else $error("resend tick without store read");

endmodule

`default_nettype wire
